FILE: hdl/active_expired_runqueue_scheduler_macros.svh
// Assertion macros shared by the scheduler RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ACTIVE_EXPIRED_RUNQUEUE_SCHEDULER_MACROS_SVH
`define ACTIVE_EXPIRED_RUNQUEUE_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AERS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AERS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/aers_pkg.sv
// Package for the active/expired run-queue scheduler.
// Holds the slot and best-candidate records, result codes, controller states and defaults; no dependencies.
`timescale 1ns / 1ps

package aers_pkg;

    // Defaults for the top-level parameter and the slice register.
    localparam int          AERS_DEPTH_DEF = 16;
    localparam logic [15:0] SLICE_RESET    = 16'd5;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_ADDED     = 3'd1,
        ST_FULL      = 3'd2,
        ST_REQUEUED  = 3'd3,
        ST_FINISHED  = 3'd4
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_DRAIN,
        S_UPDATE
    } t_state;

    // One slot of the task table as held in memory.
    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] time_left;
        logic [3:0]  prio;
        logic        set;
        logic [31:0] stamp;
    } t_entry;

    // Best candidate found by a dispatch scan.
    typedef struct packed {
        logic        found;
        logic        multi;
        logic [7:0]  id;
        logic [15:0] time_left;
        logic [3:0]  prio;
    } t_best;

endpackage

FILE: hdl/active_expired_runqueue_scheduler.sv
// Top level of the active/expired run-queue scheduler: controller, valid bits,
// slot memory and scan tracker. Depends on aers_pkg, aers_ram, aers_pick and the macros header.
//
//   Port group        Direction  Handshake
//   item in           in         start, busy (taken when start=1 and busy=0)
//   result out        out        o_strobe (one cycle, cannot be held off)
//   slice register    in         i_cfg_we, i_cfg_wdata (written when i_cfg_we=1)
//
// An add item keeps busy high through the add state; a dispatch keeps it high
// through the scan, drain and update states, the scan reading one slot per cycle
// from the slot memory. The result strobe is high in the first cycle with busy low.
// Reset is synchronous and active low; it clears valid bits, the arrival
// counter, the set flag and the slice register (to 5). The receiver cannot stall.
`timescale 1ns / 1ps
`include "active_expired_runqueue_scheduler_macros.svh"

module active_expired_runqueue_scheduler
    import aers_pkg::*;
#(
    parameter int TABLE_DEPTH = AERS_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [7:0]  i_task_id,
    input  logic [15:0] i_exec_time,
    input  logic [3:0]  i_prio_level,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output logic        o_strobe,
    output logic [2:0]  o_status,
    output logic [7:0]  o_served_id,
    output logic [15:0] o_time_left,
    output logic        o_sets_swapped
);

    localparam int            IW   = $clog2(TABLE_DEPTH);
    localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);

    t_state                 r_state, n_state;
    logic [7:0]             r_id;
    logic [15:0]            r_etime;
    logic [3:0]             r_prio;
    logic [15:0]            r_slice;
    logic [31:0]            r_arrival, n_arrival;
    logic                   r_flip, n_flip;
    logic [TABLE_DEPTH-1:0] r_valid, n_valid;
    logic [IW-1:0]          r_addr;
    logic                   r_cmp_vld;
    logic [IW-1:0]          r_cmp_idx;
    logic                   r_strobe, n_strobe;
    t_status                r_status, n_status;
    logic [7:0]             r_served, n_served;
    logic [15:0]            r_tleft, n_tleft;
    logic                   r_swap, n_swap;

    logic                   w_accept;
    logic                   w_free_ok;
    logic [IW-1:0]          w_free_idx;
    logic                   w_we;
    logic [IW-1:0]          w_waddr;
    t_entry                 w_wdata;
    t_entry                 w_rdata;
    t_best                  w_best;
    logic [IW-1:0]          w_best_idx;
    logic [15:0]            w_rem;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_rem    = w_best.time_left - r_slice;

    // Slot memory: one record per table slot.
    aers_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // Scan tracker fed with each slot as its read data returns.
    aers_pick #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_pick (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (w_accept),
        .i_cmp      (r_cmp_vld && r_valid[r_cmp_idx]),
        .i_idx      (r_cmp_idx),
        .i_entry    (w_rdata),
        .i_flip     (r_flip),
        .i_arrival  (r_arrival),
        .o_best     (w_best),
        .o_best_idx (w_best_idx)
    );

    // Lowest-numbered free slot.
    always_comb begin
        w_free_ok  = 1'b0;
        w_free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_ok  = 1'b1;
                w_free_idx = IW'(i);
            end
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = i_mode ? S_SCAN : S_ADD;
                end
            end
            S_ADD:    n_state = S_IDLE;
            S_SCAN: begin
                if (r_addr == LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN:  n_state = S_UPDATE;
            S_UPDATE: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Output and update logic: memory writes, table state and the result.
    always_comb begin
        w_we      = 1'b0;
        w_waddr   = w_free_idx;
        w_wdata   = '{id: r_id, time_left: r_etime, prio: r_prio,
                      set: r_flip, stamp: r_arrival};
        n_valid   = r_valid;
        n_arrival = r_arrival;
        n_flip    = r_flip;
        n_strobe  = 1'b0;
        n_status  = ST_IDLE;
        n_served  = '0;
        n_tleft   = '0;
        n_swap    = 1'b0;
        unique case (r_state)
            S_ADD: begin
                n_strobe = 1'b1;
                n_served = r_id;
                if (w_free_ok) begin
                    w_we                = 1'b1;
                    n_valid[w_free_idx] = 1'b1;
                    n_arrival           = r_arrival + 32'd1;
                    n_status            = ST_ADDED;
                end else begin
                    n_status = ST_FULL;
                end
            end
            S_UPDATE: begin
                n_strobe = 1'b1;
                if (w_best.found) begin
                    n_served = w_best.id;
                    n_swap   = !w_best.multi;
                    if (w_best.time_left >= r_slice) begin
                        // Requeue into the expired set with a fresh stamp.
                        w_we      = 1'b1;
                        w_waddr   = w_best_idx;
                        w_wdata   = '{id: w_best.id, time_left: w_rem, prio: w_best.prio,
                                      set: ~r_flip, stamp: r_arrival};
                        n_arrival = r_arrival + 32'd1;
                        n_tleft   = w_rem;
                        n_status  = ST_REQUEUED;
                    end else begin
                        n_valid[w_best_idx] = 1'b0;
                        n_tleft             = w_best.time_left;
                        n_status            = ST_FINISHED;
                    end
                    if (!w_best.multi) begin
                        n_flip = ~r_flip;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_slice   <= SLICE_RESET;
            r_arrival <= '0;
            r_flip    <= 1'b0;
            r_valid   <= '0;
            r_addr    <= '0;
            r_cmp_vld <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_arrival <= n_arrival;
            r_flip    <= n_flip;
            r_valid   <= n_valid;
            r_strobe  <= n_strobe;
            r_cmp_vld <= (r_state == S_SCAN);
            if (i_cfg_we) begin
                r_slice <= i_cfg_wdata;
            end
            if (r_state == S_SCAN) begin
                r_addr <= r_addr + IW'(1);
            end else begin
                r_addr <= '0;
            end
        end
    end

    // Payload registers: latched item, scan index and result.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_id    <= i_task_id;
            r_etime <= i_exec_time;
            r_prio  <= i_prio_level;
        end
        r_cmp_idx <= r_addr;
        r_status  <= n_status;
        r_served  <= n_served;
        r_tleft   <= n_tleft;
        r_swap    <= n_swap;
    end

    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_served_id    = r_served;
    assign o_time_left    = r_tleft;
    assign o_sets_swapped = r_swap;

    // A result only follows the add or update step of the controller.
    `AERS_ASSERT_IMPLY(a_strobe_src, i_clk, i_rst_n, o_strobe,
        $past(r_state) == S_ADD || $past(r_state) == S_UPDATE, "result without a finished item")
    // An accepted item makes the block busy on the next cycle.
    `AERS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, busy, "accepted item not busy")
    // A rejected add only happens when every slot was occupied.
    `AERS_ASSERT_IMPLY(a_full_valid, i_clk, i_rst_n, o_strobe && o_status == ST_FULL,
        &r_valid, "table full reported with a free slot")
    // Add results never report a swap.
    `AERS_ASSERT_IMPLY(a_add_noswap, i_clk, i_rst_n,
        o_strobe && (o_status == ST_ADDED || o_status == ST_FULL),
        !o_sets_swapped && o_time_left == 16'd0, "add result with swap or time")

endmodule

FILE: hdl/aers_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module aers_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/aers_pick.sv
// Best-candidate tracker for the dispatch scan: keeps the active slot with the
// lowest priority and, on ties, the greatest age. Depends on aers_pkg.
`timescale 1ns / 1ps

module aers_pick
    import aers_pkg::*;
#(
    parameter int TABLE_DEPTH = AERS_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_clear,
    input  logic                           i_cmp,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_idx,
    input  t_entry                         i_entry,
    input  logic                           i_flip,
    input  logic [31:0]                    i_arrival,
    output t_best                          o_best,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_best_idx
);

    localparam int IW = $clog2(TABLE_DEPTH);

    logic          r_found, n_found;
    logic          r_multi, n_multi;
    logic [IW-1:0] r_idx;
    logic [7:0]    r_id;
    logic [15:0]   r_time;
    logic [3:0]    r_prio;
    logic [31:0]   r_age;
    logic          w_active;
    logic          w_take;
    logic [31:0]   w_age;

    // An entry competes when it is valid and belongs to the active set.
    assign w_active = i_cmp && (i_entry.set == i_flip);
    assign w_age    = i_arrival - i_entry.stamp;
    assign w_take   = w_active && (!r_found || (i_entry.prio < r_prio) ||
                      ((i_entry.prio == r_prio) && (w_age > r_age)));

    // Found and multiple-active flags.
    always_comb begin
        n_found = r_found;
        n_multi = r_multi;
        if (i_clear) begin
            n_found = 1'b0;
            n_multi = 1'b0;
        end else if (w_active) begin
            n_found = 1'b1;
            n_multi = r_multi | r_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_multi <= 1'b0;
        end else begin
            r_found <= n_found;
            r_multi <= n_multi;
        end
    end

    // Candidate payload; only meaningful while the found flag is set.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_idx  <= i_idx;
            r_id   <= i_entry.id;
            r_time <= i_entry.time_left;
            r_prio <= i_entry.prio;
            r_age  <= w_age;
        end
    end

    assign o_best.found     = r_found;
    assign o_best.multi     = r_multi;
    assign o_best.id        = r_id;
    assign o_best.time_left = r_time;
    assign o_best.prio      = r_prio;
    assign o_best_idx       = r_idx;

endmodule
